>>> rtl/core/alvt_pkg.sv
// Shared constants, codes and types of the altitude low-pass velocity tracker.
// Used by the interfaces, the register block, the controller and the datapath.
`default_nettype none

package alvt_pkg;

	// Field widths
	localparam int TICK_W = 32;
	localparam int RAW_W  = 16;
	localparam int CFG_W  = 16;
	localparam int ALT_W  = 25;
	localparam int VEL_W  = 24;

	// Velocity window; the length must be a power of two (mean is a shift)
	localparam int WINDOW_LEN = 8;
	localparam int WIN_SHIFT  = $clog2(WINDOW_LEN);
	localparam int SLOT_W     = (WIN_SHIFT > 0) ? WIN_SHIFT : 1;
	localparam int SUM_W      = VEL_W + WIN_SHIFT;

	// Gain path: product of rate and the low part of the interval
	localparam int DT_LO_W   = 18;
	localparam int PROD_W    = CFG_W + DT_LO_W;
	localparam int GAIN_W    = 9;
	localparam int RECIP_W   = 19;
	localparam int RECIP_SH  = 28;
	localparam logic [GAIN_W-1:0]  GAIN_ONE      = 9'd256;
	localparam logic [PROD_W-1:0]  GAIN_SAT_PROD = 34'd257000;
	// floor(p / 1000) == (p * RECIP_M) >> RECIP_SH for every p below GAIN_SAT_PROD
	localparam logic [RECIP_W-1:0] RECIP_M       = 19'd268436;

	// Filter and velocity path
	localparam int DIFF_W  = ALT_W + 1;
	localparam int GD_W    = 35;
	localparam int STEP_W  = GD_W - 8;
	localparam int MS_W    = 10;
	localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;
	localparam int DIV_W   = 35;
	localparam int CNT_W   = $clog2(DIV_W);

	localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
	localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_GROUND = 1'b0;
	localparam logic REG_RATE   = 1'b1;
	localparam logic [CFG_W-1:0] RATE_RESET = 16'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN1,
		ST_GAIN2,
		ST_FILT,
		ST_VEL,
		ST_DIV,
		ST_WIN
	} state_t;

	typedef struct packed {
		logic load;
		logic gain1;
		logic gain2;
		logic filt;
		logic vel;
		logic div_step;
		logic win;
	} cmd_t;

	typedef struct packed {
		logic zero_dt;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/alvt_if.sv
// Valid/ready channel interfaces for samples in and results out.
// Depends on alvt_pkg for the field widths.
`default_nettype none

interface alvt_sample_if;
	logic                          valid;
	logic                          ready;
	logic [alvt_pkg::TICK_W-1:0]   tick_ms;
	logic [alvt_pkg::RAW_W-1:0]    raw_altitude;

	modport source (output valid, output tick_ms, output raw_altitude, input ready);
	modport sink (input valid, input tick_ms, input raw_altitude, output ready);
endinterface

interface alvt_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [alvt_pkg::ALT_W-1:0]  filtered_altitude;
	logic signed [alvt_pkg::VEL_W-1:0]  mean_velocity;
	logic                               zero_interval;

	modport source (output valid, output filtered_altitude, output mean_velocity,
		output zero_interval, input ready);
	modport sink (input valid, input filtered_altitude, input mean_velocity,
		input zero_interval, output ready);
endinterface

`default_nettype wire

>>> rtl/core/alvt_regs.sv
// APB-style configuration registers: ground altitude and filter rate.
// Depends on alvt_pkg for widths and register indexes.
`default_nettype none

module alvt_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [alvt_pkg::APB_AW-1:0]   paddr,
	input  wire logic [alvt_pkg::APB_DW-1:0]   pwdata,
	output logic      [alvt_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [alvt_pkg::CFG_W-1:0]    ground,
	output logic      [alvt_pkg::CFG_W-1:0]    rate
);

	logic [alvt_pkg::CFG_W-1:0] ground_q;
	logic [alvt_pkg::CFG_W-1:0] rate_q;
	logic                       wr_en;
	logic                       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q <= '0;
			rate_q   <= alvt_pkg::RATE_RESET;
		end else if (wr_en) begin
			if (reg_idx == alvt_pkg::REG_GROUND) begin
				ground_q <= pwdata[alvt_pkg::CFG_W-1:0];
			end else begin
				rate_q <= pwdata[alvt_pkg::CFG_W-1:0];
			end
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		if (reg_idx == alvt_pkg::REG_GROUND) begin
			prdata[alvt_pkg::CFG_W-1:0] = ground_q;
		end else begin
			prdata[alvt_pkg::CFG_W-1:0] = rate_q;
		end
	end

	assign ground = ground_q;
	assign rate   = rate_q;

endmodule

`default_nettype wire

>>> rtl/core/alvt_ctrl.sv
// Controller state machine: sequences gain, filter, divide and window steps.
// Depends on alvt_pkg for the state enum and the command/status structs.
`default_nettype none

module alvt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire alvt_pkg::status_t status,
	output alvt_pkg::cmd_t         cmd
);

	alvt_pkg::state_t              state_q;
	alvt_pkg::state_t              state_d;
	logic [alvt_pkg::CNT_W-1:0]    cnt_q;
	logic [alvt_pkg::CNT_W-1:0]    cnt_d;

	// State and divide counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alvt_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			alvt_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = alvt_pkg::ST_GAIN1;
				end
			end
			alvt_pkg::ST_GAIN1: begin
				cmd.gain1 = 1'b1;
				state_d   = alvt_pkg::ST_GAIN2;
			end
			alvt_pkg::ST_GAIN2: begin
				cmd.gain2 = 1'b1;
				state_d   = alvt_pkg::ST_FILT;
			end
			alvt_pkg::ST_FILT: begin
				cmd.filt = 1'b1;
				state_d  = alvt_pkg::ST_VEL;
			end
			alvt_pkg::ST_VEL: begin
				cmd.vel = 1'b1;
				cnt_d   = '0;
				// Zero interval needs no divide
				state_d = status.zero_dt ? alvt_pkg::ST_WIN : alvt_pkg::ST_DIV;
			end
			alvt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == alvt_pkg::CNT_W'(alvt_pkg::DIV_W - 1)) begin
					state_d = alvt_pkg::ST_WIN;
				end
			end
			alvt_pkg::ST_WIN: begin
				// Hold until the output register can take the result
				if (!status.out_busy) begin
					cmd.win = 1'b1;
					state_d = alvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = alvt_pkg::ST_IDLE;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> (state_q == alvt_pkg::ST_GAIN1))
		else $error("accepted sample did not start the gain step");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alvt_pkg::ST_DIV && cnt_q == alvt_pkg::CNT_W'(alvt_pkg::DIV_W - 1))
		|=> (state_q == alvt_pkg::ST_WIN))
		else $error("divide did not end after its last step");

	a_zero_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alvt_pkg::ST_VEL && status.zero_dt) |=> (state_q == alvt_pkg::ST_WIN))
		else $error("zero interval entered the divider");

endmodule

`default_nettype wire

>>> rtl/core/alvt_dp.sv
// Datapath: interval, gain, low-pass filter, serial divider, velocity window
// and the output register. Depends on alvt_pkg; driven by alvt_ctrl commands.
`default_nettype none

module alvt_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire alvt_pkg::cmd_t                       cmd,
	output alvt_pkg::status_t                         status,
	input  wire logic [alvt_pkg::CFG_W-1:0]           ground,
	input  wire logic [alvt_pkg::CFG_W-1:0]           rate,
	input  wire logic [alvt_pkg::TICK_W-1:0]          tick_ms,
	input  wire logic [alvt_pkg::RAW_W-1:0]           raw_altitude,
	output logic                                      res_valid,
	input  wire logic                                 res_ready,
	output logic signed [alvt_pkg::ALT_W-1:0]         res_filtered,
	output logic signed [alvt_pkg::VEL_W-1:0]         res_mean,
	output logic                                      res_zero
);

	localparam int AW = alvt_pkg::ALT_W;
	localparam int VW = alvt_pkg::VEL_W;
	localparam int SW = alvt_pkg::SUM_W;

	// Persistent state
	logic [alvt_pkg::TICK_W-1:0]        last_tick_q;
	logic signed [AW-1:0]               last_filt_q;
	logic signed [VW-1:0]               win_q [alvt_pkg::WINDOW_LEN];
	logic signed [SW-1:0]               sum_q;
	logic [alvt_pkg::SLOT_W-1:0]        slot_q;

	// Per-sample working registers
	logic [alvt_pkg::TICK_W-1:0]        dt_q;
	logic                               zero_q;
	logic signed [AW-1:0]               alt_q;
	logic [alvt_pkg::PROD_W-1:0]        prod_q;
	logic                               sat_q;
	logic [alvt_pkg::GAIN_W-1:0]        g_q;
	logic signed [alvt_pkg::GD_W-1:0]   gd_q;
	logic                               neg_q;
	logic [alvt_pkg::DIV_W-1:0]         quo_q;
	logic [alvt_pkg::TICK_W-1:0]        rem_q;

	// Output register
	logic                               out_valid_q;
	logic signed [AW-1:0]               out_filt_q;
	logic signed [VW-1:0]               out_mean_q;
	logic                               out_zero_q;

	// Combinational terms
	logic signed [16:0]                                 alt_diff;
	logic [alvt_pkg::TICK_W-1:0]                        dt_w;
	logic [alvt_pkg::PROD_W-1:0]                        prod_w;
	logic [alvt_pkg::DT_LO_W+alvt_pkg::RECIP_W-1:0]     recip_w;
	logic signed [alvt_pkg::DIFF_W-1:0]                 diff_w;
	logic signed [alvt_pkg::GAIN_W+alvt_pkg::DIFF_W:0]  gd_full;
	logic signed [alvt_pkg::GD_W-1:0]                   rnd_w;
	logic signed [alvt_pkg::STEP_W-1:0]                 step_w;
	logic signed [alvt_pkg::STEP_W-1:0]                 filt_w;
	logic [alvt_pkg::STEP_W-1:0]                        abs_step;
	logic [alvt_pkg::DIFF_W+alvt_pkg::MS_W-1:0]         mag_full;
	logic [alvt_pkg::TICK_W:0]                          shift_w;
	logic                                               ge_w;
	logic [alvt_pkg::TICK_W:0]                          sub_w;
	logic signed [VW-1:0]                               vel_w;
	logic signed [SW-1:0]                               sum_new;
	logic signed [SW-1:0]                               bias_w;
	logic signed [SW-1:0]                               mean_full;

	// Height above ground in Q.8 and elapsed time
	assign alt_diff = $signed({1'b0, raw_altitude}) - $signed({1'b0, ground});
	assign dt_w     = tick_ms - last_tick_q;

	// Gain: rate times interval, scaled by 1/1000 through a reciprocal
	assign prod_w  = alvt_pkg::PROD_W'(rate) * alvt_pkg::PROD_W'(dt_q[alvt_pkg::DT_LO_W-1:0]);
	assign recip_w = (alvt_pkg::DT_LO_W + alvt_pkg::RECIP_W)'(prod_q[alvt_pkg::DT_LO_W-1:0])
		* (alvt_pkg::DT_LO_W + alvt_pkg::RECIP_W)'(alvt_pkg::RECIP_M);

	// Filter increment g * (alt - last)
	assign diff_w  = $signed({alt_q[AW-1], alt_q}) - $signed({last_filt_q[AW-1], last_filt_q});
	assign gd_full = $signed({1'b0, g_q}) * diff_w;

	// Round the increment, form the new filtered value and |step| * 1000
	assign rnd_w    = gd_q + alvt_pkg::GD_W'(128);
	assign step_w   = rnd_w[alvt_pkg::GD_W-1:8];
	assign filt_w   = $signed({{(alvt_pkg::STEP_W-AW){last_filt_q[AW-1]}}, last_filt_q}) + step_w;
	assign abs_step = step_w[alvt_pkg::STEP_W-1] ? (~step_w + 1'b1) : step_w;
	assign mag_full = (alvt_pkg::DIFF_W + alvt_pkg::MS_W)'(abs_step[alvt_pkg::DIFF_W-1:0])
		* (alvt_pkg::DIFF_W + alvt_pkg::MS_W)'(alvt_pkg::MS_PER_S);

	// One restoring divide step
	assign shift_w = {rem_q, quo_q[alvt_pkg::DIV_W-1]};
	assign ge_w    = shift_w >= {1'b0, dt_q};
	assign sub_w   = shift_w - {1'b0, dt_q};

	// Signed, saturated velocity from the quotient
	always_comb begin
		if (zero_q) begin
			vel_w = '0;
		end else if (neg_q) begin
			if (quo_q > alvt_pkg::DIV_W'(2 ** (VW - 1))) begin
				vel_w = alvt_pkg::VEL_MIN;
			end else begin
				vel_w = $signed(~quo_q[VW-1:0] + 1'b1);
			end
		end else begin
			if (quo_q > alvt_pkg::DIV_W'(alvt_pkg::VEL_MAX)) begin
				vel_w = alvt_pkg::VEL_MAX;
			end else begin
				vel_w = $signed(quo_q[VW-1:0]);
			end
		end
	end

	// Window sum and mean, truncated toward zero
	assign sum_new   = sum_q + $signed({{(SW-VW){vel_w[VW-1]}}, vel_w})
		- $signed({{(SW-VW){win_q[slot_q][VW-1]}}, win_q[slot_q]});
	assign bias_w    = sum_new[SW-1] ? SW'(alvt_pkg::WINDOW_LEN - 1) : '0;
	assign mean_full = (sum_new + bias_w) >>> alvt_pkg::WIN_SHIFT;

	// Persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			last_filt_q <= '0;
			sum_q       <= '0;
			slot_q      <= '0;
			for (int i = 0; i < alvt_pkg::WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				last_tick_q <= tick_ms;
			end
			if (cmd.vel) begin
				last_filt_q <= filt_w[AW-1:0];
			end
			if (cmd.win) begin
				win_q[slot_q] <= vel_w;
				sum_q         <= sum_new;
				if (slot_q == alvt_pkg::SLOT_W'(alvt_pkg::WINDOW_LEN - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// Working registers for one sample
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dt_q   <= dt_w;
			zero_q <= (dt_w == '0);
			alt_q  <= $signed({alt_diff, 8'h00});
		end
		if (cmd.gain1) begin
			prod_q <= prod_w;
			sat_q  <= (|dt_q[alvt_pkg::TICK_W-1:alvt_pkg::DT_LO_W]) && (rate != '0);
		end
		if (cmd.gain2) begin
			if (sat_q || prod_q >= alvt_pkg::GAIN_SAT_PROD) begin
				g_q <= alvt_pkg::GAIN_ONE;
			end else begin
				g_q <= recip_w[alvt_pkg::RECIP_SH+alvt_pkg::GAIN_W-1:alvt_pkg::RECIP_SH];
			end
		end
		if (cmd.filt) begin
			gd_q <= gd_full[alvt_pkg::GD_W-1:0];
		end
		if (cmd.vel) begin
			neg_q <= (step_w > 0);
			quo_q <= mag_full[alvt_pkg::DIV_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge_w ? sub_w[alvt_pkg::TICK_W-1:0] : shift_w[alvt_pkg::TICK_W-1:0];
			quo_q <= {quo_q[alvt_pkg::DIV_W-2:0], ge_w};
		end
	end

	// Output register: fill on window update, drain on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.win) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win) begin
			out_filt_q <= last_filt_q;
			out_mean_q <= mean_full[VW-1:0];
			out_zero_q <= zero_q;
		end
	end

	assign status.zero_dt  = zero_q;
	assign status.out_busy = out_valid_q && !res_ready;

	assign res_valid    = out_valid_q;
	assign res_filtered = out_filt_q;
	assign res_mean     = out_mean_q;
	assign res_zero     = out_zero_q;

	a_gain_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.filt |-> (g_q <= alvt_pkg::GAIN_ONE))
		else $error("filter gain above unity");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < dt_q))
		else $error("divider remainder not below the interval");

	a_filt_between: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vel |=> ((last_filt_q >= $past(last_filt_q) && last_filt_q <= alt_q)
			|| (last_filt_q <= $past(last_filt_q) && last_filt_q >= alt_q)))
		else $error("filtered value left the range between old value and input");

endmodule

`default_nettype wire

>>> rtl/core/altitude_lowpass_velocity_tracker_top.sv
// Top level of the altitude low-pass velocity tracker.
// Depends on alvt_pkg, alvt_if, alvt_regs, alvt_ctrl and alvt_dp.
//
// Each sample (millisecond tick, raw altitude in feet) yields one result:
// the low-pass filtered height above ground, the mean of the last eight
// velocities in ft/s (positive while descending), both signed Q.8, and a
// flag for a zero interval, in which case the velocity is taken as zero.
// A sample runs through the gain, filter and velocity steps, the 35-step serial
// divider that forms the velocity, and the window step; a zero interval skips
// the divider. The next sample is taken as soon as the controller is back at
// rest, while the previous result may still wait in the output register.
// Write ground_altitude (0x0) and filter_rate (0x4) only while no sample is
// in flight.
`default_nettype none

module altitude_lowpass_velocity_tracker_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	alvt_sample_if.sink                        sample,
	alvt_result_if.source                      result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [alvt_pkg::APB_AW-1:0]   paddr,
	input  wire logic [alvt_pkg::APB_DW-1:0]   pwdata,
	output logic      [alvt_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	logic [alvt_pkg::CFG_W-1:0] ground;
	logic [alvt_pkg::CFG_W-1:0] rate;
	alvt_pkg::cmd_t             cmd;
	alvt_pkg::status_t          status;
	logic                       sample_ready;

	// Configuration registers
	alvt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ground  (ground),
		.rate    (rate)
	);

	// Sequencer
	alvt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample_ready),
		.status       (status),
		.cmd          (cmd)
	);

	assign sample.ready = sample_ready;

	// Arithmetic and state
	alvt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.ground       (ground),
		.rate         (rate),
		.tick_ms      (sample.tick_ms),
		.raw_altitude (sample.raw_altitude),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.res_filtered (result.filtered_altitude),
		.res_mean     (result.mean_velocity),
		.res_zero     (result.zero_interval)
	);

endmodule

`default_nettype wire

>>> tb/alvt_track_checker.sv
`timescale 1ns / 100ps
// Checker for the altitude low-pass velocity tracker: follows the register port and both
// channels, predicts every result and compares it field by field with what comes out.
// Depends on alvt_pkg and the channel interfaces of alvt_if.

module alvt_track_checker
	import alvt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	alvt_sample_if            sample,
	alvt_result_if            result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                checked,
	output int                zero_hits
);

	localparam longint ONE_Q8      = 256;
	localparam longint ROUND_HALF  = 128;
	localparam longint MS_PER_SEC  = 1000;
	localparam int     MAX_PRINTED = 100;

	typedef struct {
		logic signed [ALT_W-1:0] filtered;
		logic signed [VEL_W-1:0] mean;
		logic                    zero;
	} track_fix_t;

	// Predicted results, oldest first
	track_fix_t fix_queue[$];

	// Register copies and tracker state
	logic [CFG_W-1:0]  ground_ft = '0;
	logic [CFG_W-1:0]  rate_q8   = RATE_RESET;
	logic [TICK_W-1:0] prev_tick = '0;
	longint            prev_filt = 0;
	longint            vel_sum   = 0;
	longint            vel_hist[WINDOW_LEN];
	int                hist_slot = 0;

	task automatic flag_mismatch(input string msg);
		if (fail_count < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic longint clamp_vel(input longint v);
		if (v > longint'(VEL_MAX))
			return longint'(VEL_MAX);
		if (v < longint'(VEL_MIN))
			return longint'(VEL_MIN);
		return v;
	endfunction

	// Advance the filter and the velocity window by one sample
	function automatic track_fix_t follow_sample(input logic [TICK_W-1:0] tick,
			input logic [RAW_W-1:0] raw);
		logic [TICK_W-1:0] dt;
		longint dt_ms, raw_ft, ground, rate, height, gain, filt, vel, mean;
		track_fix_t fix;
		dt     = tick - prev_tick;
		dt_ms  = dt;
		raw_ft = raw;
		ground = ground_ft;
		rate   = rate_q8;
		height = (raw_ft - ground) * ONE_Q8;
		gain   = rate * dt_ms / MS_PER_SEC;
		if (gain > ONE_Q8)
			gain = ONE_Q8;
		// round to nearest, ties upward: arithmetic shift floors
		filt = ((ONE_Q8 - gain) * prev_filt + gain * height + ROUND_HALF) >>> 8;
		if (dt == '0)
			vel = 0;
		else
			vel = clamp_vel(((prev_filt - filt) * MS_PER_SEC) / dt_ms);
		prev_tick = tick;
		prev_filt = filt;
		vel_sum   = vel_sum + vel - vel_hist[hist_slot];
		vel_hist[hist_slot] = vel;
		hist_slot = (hist_slot + 1) % WINDOW_LEN;
		mean = clamp_vel(vel_sum / WINDOW_LEN);
		fix.filtered = filt[ALT_W-1:0];
		fix.mean     = mean[VEL_W-1:0];
		fix.zero     = (dt == '0);
		return fix;
	endfunction

	always @(posedge clk) begin
		track_fix_t want;
		logic [CFG_W-1:0] reg_val;
		if (!arst_n) begin
			// hold everything at its reset value
			ground_ft = '0;
			rate_q8   = RATE_RESET;
			prev_tick = '0;
			prev_filt = 0;
			vel_sum   = 0;
			hist_slot = 0;
			foreach (vel_hist[i])
				vel_hist[i] = 0;
			fix_queue.delete();
		end else begin
			// Register port: track writes, check reads
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[APB_AW-1:2] == REG_GROUND)
						ground_ft = pwdata[CFG_W-1:0];
					else
						rate_q8 = pwdata[CFG_W-1:0];
				end else begin
					reg_val = (paddr[APB_AW-1:2] == REG_RATE) ? rate_q8 : ground_ft;
					if (prdata !== {{(APB_DW-CFG_W){1'b0}}, reg_val})
						flag_mismatch($sformatf("register read at 0x%0h gave 0x%0h, expected 0x%0h",
							paddr, prdata, reg_val));
				end
			end

			// Result transaction: compare with the oldest prediction
			if (result.valid && result.ready) begin
				if (fix_queue.size() == 0) begin
					flag_mismatch($sformatf("unexpected result: filtered %0d, mean %0d, zero %0b",
						result.filtered_altitude, result.mean_velocity, result.zero_interval));
				end else begin
					want = fix_queue.pop_front();
					checked++;
					if (want.zero)
						zero_hits++;
					if (result.filtered_altitude !== want.filtered)
						flag_mismatch($sformatf("result %0d: filtered_altitude %0d, expected %0d",
							checked, result.filtered_altitude, want.filtered));
					if (result.mean_velocity !== want.mean)
						flag_mismatch($sformatf("result %0d: mean_velocity %0d, expected %0d",
							checked, result.mean_velocity, want.mean));
					if (result.zero_interval !== want.zero)
						flag_mismatch($sformatf("result %0d: zero_interval %0b, expected %0b",
							checked, result.zero_interval, want.zero));
				end
			end

			// Sample transaction: predict its result
			if (sample.valid && sample.ready)
				fix_queue.push_back(follow_sample(sample.tick_ms, sample.raw_altitude));
		end
		pending = fix_queue.size();
	end

endmodule

>>> tb/tb_altitude_lowpass_velocity_tracker_top.sv
`timescale 1ns / 100ps
// Testbench top for the altitude low-pass velocity tracker: drives samples and register
// settings under random idling, long output stalls and drains, and gives the verdict.
// Depends on alvt_pkg, alvt_if, the tracker RTL and alvt_track_checker.

module tb_altitude_lowpass_velocity_tracker_top;
	import alvt_pkg::*;

	localparam int HALF_HIGH_NS      = 6;
	localparam int HALF_LOW_NS       = 6;
	localparam int RESET_CYCLES      = 9;
	localparam int SETTLE_CYCLES     = 48;
	localparam int LONG_HOLD_CYCLES  = 400;
	localparam int SETTINGS_PER_MODE = 5;
	localparam int LEG_SAMPLES       = 65;
	localparam int TIMEOUT_NS        = 10_000_000;
	localparam logic [APB_AW-1:0] ADDR_GROUND = {REG_GROUND, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_RATE   = {REG_RATE, 2'b00};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatches;
	int outstanding;
	int results_checked;
	int zero_results;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int holds_started;
	int hold_left;
	int cur_ground;
	int settings_used;
	logic [TICK_W-1:0] flight_tick;

	alvt_sample_if sample_ch ();
	alvt_result_if result_ch ();

	altitude_lowpass_velocity_tracker_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	alvt_track_checker tracker_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (mismatches),
		.pending    (outstanding),
		.checked    (results_checked),
		.zero_hits  (zero_results)
	);

	always begin
		#HALF_LOW_NS clk = 1'b1;
		#HALF_HIGH_NS clk = 1'b0;
	end

	// Stop a hung run
	initial begin
		#TIMEOUT_NS;
		$display("Timeout with %0d results still outstanding", outstanding);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result receiver: random idling, plus long hold-offs on request
	initial begin
		result_ch.ready = 1'b0;
		holds_started = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_started < hold_requests) begin
				holds_started++;
				hold_left = LONG_HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one sample, idling first at random; return at its accepting edge
	task automatic send_sample(input logic [TICK_W-1:0] tick, input logic [RAW_W-1:0] raw);
		logic took;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.tick_ms      <= tick;
		sample_ch.raw_altitude <= raw;
		do begin
			@(negedge clk);
			took = sample_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Stop offering and wait for every predicted result
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	// Drain, then let the block come to rest
	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register transaction: setup cycle, then access until pready
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers with junk in the unused upper bits, then read them back
	task automatic program_registers(input logic [CFG_W-1:0] ground, input logic [CFG_W-1:0] rate);
		logic [APB_DW-CFG_W-1:0] junk;
		junk = $urandom;
		apb_access(1'b1, ADDR_GROUND, {junk, ground});
		junk = $urandom;
		apb_access(1'b1, ADDR_RATE, {junk, rate});
		apb_access(1'b0, ADDR_GROUND, '0);
		apb_access(1'b0, ADDR_RATE, '0);
		cur_ground = ground;
		settings_used++;
	endtask

	// Choose a setting, extremes included
	task automatic pick_setting();
		logic [CFG_W-1:0] ground, rate;
		case ($urandom_range(4))
			0: ground = '0;
			1: ground = '1;
			2: ground = $urandom;
			default: ground = $urandom_range(3000);
		endcase
		case ($urandom_range(4))
			0: rate = '0;
			1: rate = '1;
			2: rate = $urandom;
			default: rate = $urandom_range(1024);
		endcase
		program_registers(ground, rate);
	endtask

	// Climb then descend with jittered readings and varied intervals, with some noise
	task automatic fly_leg(input int count);
		int height, climb, step, reading, pick;
		logic [RAW_W-1:0] junk_raw;
		height = cur_ground + int'($urandom_range(4000));
		climb  = $urandom_range(400, 5);
		if ($urandom_range(3) == 0)
			flight_tick = 32'hFFFF_FFFF - $urandom_range(20000);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 15) begin
				// noise: arbitrary reading, tick jumps or repeats
				if ($urandom_range(3) != 0)
					flight_tick = $urandom;
				junk_raw = $urandom;
				send_sample(flight_tick, junk_raw);
			end else begin
				pick = $urandom_range(99);
				if (pick < 5)
					step = 0;
				else if (pick < 30)
					step = $urandom_range(20, 1);
				else if (pick < 90)
					step = $urandom_range(200, 21);
				else
					step = $urandom_range(3000, 201);
				flight_tick += step;
				height += (i < count / 2) ? climb : -climb;
				reading = height + int'($urandom_range(60)) - 30;
				if (reading < 0)
					reading = 0;
				else if (reading > 65535)
					reading = 65535;
				send_sample(flight_tick, reading[RAW_W-1:0]);
			end
		end
	endtask

	// One idling mode over several settings, with a long stall and a drain
	task automatic run_mode(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
			settle_block();
			pick_setting();
			fly_leg(LEG_SAMPLES);
			if (s == 1)
				hold_requests <= hold_requests + 1;
			if (s == 3)
				drain_results();
			fly_leg(LEG_SAMPLES);
		end
	endtask

	initial begin
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.tick_ms      = '0;
		sample_ch.raw_altitude = '0;
		send_idle_pct          = 0;
		recv_idle_pct          = 0;
		hold_requests          = 0;
		cur_ground             = 0;
		settings_used          = 1;
		flight_tick            = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of both registers
		apb_access(1'b0, ADDR_GROUND, '0);
		apb_access(1'b0, ADDR_RATE, '0);

		// Reset setting: first sample has no elapsed time, then full, none and partial gain
		send_sample(32'd0, 16'd0);
		send_sample(32'd1000, 16'hFFFF);
		send_sample(32'd1000, 16'd100);
		send_sample(32'd1001, 16'd0);
		send_sample(32'd1500, 16'd0);
		send_sample(32'd2500, 16'd300);

		// Ground above the reading, fastest rate, saturated velocity, tick wrap
		settle_block();
		program_registers('1, '1);
		send_sample(32'd2501, 16'd0);
		send_sample(32'd2502, 16'hFFFF);
		send_sample(32'hFFFF_FFF0, 16'd0);
		send_sample(32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'd5, 16'd1);
		send_sample(32'd5, 16'd1);

		// Zero rate: the filter never moves
		settle_block();
		program_registers('0, '0);
		send_sample(32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'h8000_0000, 16'h5555);
		send_sample(32'h8000_0000, 16'hAAAA);

		run_mode(19, 61);
		run_mode(61, 19);
		run_mode(0, 0);

		settle_block();
		$display("Checked %0d results (%0d with no elapsed time) over %0d register settings,",
			results_checked, zero_results, settings_used);
		$display("under sender and receiver idling, long output stalls and full drains.");
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> altitude_lowpass_velocity_tracker_top.f
rtl/core/alvt_pkg.sv
rtl/core/alvt_if.sv
rtl/core/alvt_regs.sv
rtl/core/alvt_ctrl.sv
rtl/core/alvt_dp.sv
rtl/core/altitude_lowpass_velocity_tracker_top.sv
tb/alvt_track_checker.sv
tb/tb_altitude_lowpass_velocity_tracker_top.sv
